// File: src/cbl_pkg.sv
// cbl_pkg: shared types, constants and helpers for the cascaded biquad low-pass unit
// no dependencies; used by cascaded_biquad_lowpass_unit and cbl_checker
package cbl_pkg;

  localparam int NUM_CHANNELS_DEF = 2;
  localparam int NUM_SECTIONS     = 5;
  localparam int SEC_W            = 3;
  localparam int SAMPLE_W         = 16;
  localparam int WORD_W           = 25;
  localparam int ACC_W            = 32;
  localparam int COEF_W           = 16;
  localparam int DIGIT_W          = 4;
  localparam int FB_DIGITS        = 3;
  localparam int FF_DIGITS        = 4;
  localparam int DIG_W            = 2;
  localparam int FB_SHIFT         = 7;
  localparam int FF_REG_W         = 48;
  localparam int CFG_ADDR_W       = 3;

  localparam logic [CFG_ADDR_W-1:0] REG_STEREO_MODE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTION0_FF = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTION4_FF = 3'd5;

  localparam logic [FF_REG_W-1:0] FF_RESET [NUM_SECTIONS] = '{
    48'd511090294902, 48'd768783483058, 48'd1176800461073,
    48'd1743741452693, 48'd867599581386
  };

  localparam logic signed [COEF_W-1:0] FB_A1 [NUM_SECTIONS] = '{
    16'sd211, 16'sd207, 16'sd201, 16'sd198, 16'sd199
  };
  localparam logic signed [COEF_W-1:0] FB_A2 [NUM_SECTIONS] = '{
    -16'sd89, -16'sd98, -16'sd110, -16'sd119, -16'sd125
  };
  localparam logic [2:0] IN_SHIFT [NUM_SECTIONS] = '{3'd3, 3'd3, 3'd5, 3'd5, 3'd3};

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       channel;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] sample_out;
    logic                     channel_out;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD_FB,
    ST_FB,
    ST_LOAD_FF,
    ST_FF,
    ST_WRITE,
    ST_FINISH
  } state_t;

  // multiplicand times one 4-bit coefficient digit, signed when it is the top digit
  function automatic logic [ACC_W-1:0] mul_digit(logic [ACC_W-1:0] m,
                                                 logic [DIGIT_W-1:0] d,
                                                 logic top);
    logic signed [DIGIT_W:0]       ds;
    logic signed [ACC_W+DIGIT_W:0] p;
    ds = {top & d[DIGIT_W-1], d};
    p  = $signed(m) * ds;
    return p[ACC_W-1:0];
  endfunction

endpackage

// File: src/cascaded_biquad_lowpass_unit.sv
// cascaded_biquad_lowpass_unit: five cascaded direct-form-II biquad sections, digit serial
// depends on cbl_pkg; cbl_checker is bound to it in its own file
//
// usage:
//   in channel: in_valid/in_ready with in_data (sample_in, channel). an item is taken
//   at a clock edge with both high; in_ready is high only while the block is free.
//   out channel: out_valid/out_ready with out_data (sample_out, channel_out), held in
//   an output register until taken.
//   cfg port: cfg_we, cfg_addr, cfg_data; index 0 stereo_mode, 1..5 section
//   feedforward words. write only while no item is in flight.
//   each section steps through delay memory read, load, 3 feedback digits, load,
//   4 feedforward digits and write back; all products go 4 coefficient bits per
//   cycle through one set of three 32x5 digit multipliers. a new item is taken
//   only after the last one has been moved into the output register.
//   a stalled receiver does not stop the next item: the block finishes it into its
//   own state and waits with it until the output register is free.
//   reset (rst_n low, synchronous) clears all delay words via per-entry valid bits,
//   restores the feedforward reset coefficients and stereo_mode 0, and drops out_valid.
module cascaded_biquad_lowpass_unit #(
  parameter int NUM_CHANNELS = cbl_pkg::NUM_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  cbl_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output cbl_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [cbl_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [cbl_pkg::FF_REG_W-1:0]       cfg_data
);

  localparam int DEPTH  = NUM_CHANNELS * cbl_pkg::NUM_SECTIONS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int W      = cbl_pkg::WORD_W;
  localparam int AW     = cbl_pkg::ACC_W;
  localparam int CW     = cbl_pkg::COEF_W;
  localparam int DW     = cbl_pkg::DIGIT_W;
  localparam int SEC_W  = cbl_pkg::SEC_W;
  localparam int DIG_W  = cbl_pkg::DIG_W;

  cbl_pkg::state_t state_r, state_nxt;

  logic                          stereo_r;
  logic [cbl_pkg::FF_REG_W-1:0]  ff_r [cbl_pkg::NUM_SECTIONS];

  logic [SEC_W-1:0]   sec_r;
  logic [DIG_W-1:0]   dig_r;
  logic               ch_r;
  logic               chin_r;
  logic [W-1:0]       x_r, w0_r, w1_r, w2_r;
  logic [AW-1:0]      acc_r, acc_nxt;
  logic [AW-1:0]      m_r [3];
  logic [CW-1:0]      c_r [3];
  logic               top_digit;
  logic               last_digit;

  logic [2*W-1:0]     mem [DEPTH];
  logic [DEPTH-1:0]   valid_r;
  logic [2*W-1:0]     rd_data_r;
  logic               rd_valid_r;
  logic [ADDR_W-1:0]  addr;
  logic [W-1:0]       rd_w1, rd_w2;
  logic [AW-1:0]      x_shift;
  logic [cbl_pkg::FF_REG_W-1:0] ff_sel;

  logic               out_valid_r;
  cbl_pkg::out_item_t out_r;

  logic in_fire, out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stereo_r <= 1'b0;
      for (int i = 0; i < cbl_pkg::NUM_SECTIONS; i++) ff_r[i] <= cbl_pkg::FF_RESET[i];
    end else if (cfg_we) begin
      unique case (cfg_addr) inside
        cbl_pkg::REG_STEREO_MODE: stereo_r <= cfg_data[0];
        [cbl_pkg::REG_SECTION0_FF:cbl_pkg::REG_SECTION4_FF]:
          ff_r[SEC_W'(cfg_addr - cbl_pkg::REG_SECTION0_FF)] <= cfg_data;
        default: ;
      endcase
    end
  end

  // delay word memory, one entry {w2, w1} per channel and section
  assign addr = ch_r ? ADDR_W'(cbl_pkg::NUM_SECTIONS) + ADDR_W'(sec_r) : ADDR_W'(sec_r);

  always_ff @(posedge clk) begin
    rd_data_r <= mem[addr];
    if (state_r == cbl_pkg::ST_WRITE) mem[addr] <= {w1_r, w0_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[addr];
      if (state_r == cbl_pkg::ST_WRITE) valid_r[addr] <= 1'b1;
    end
  end

  assign rd_w1 = rd_valid_r ? rd_data_r[W-1:0]   : '0;
  assign rd_w2 = rd_valid_r ? rd_data_r[2*W-1:W] : '0;

  // digit-serial multiply-accumulate
  assign top_digit  = (state_r == cbl_pkg::ST_FB) ?
                      (dig_r == DIG_W'(cbl_pkg::FB_DIGITS - 1)) :
                      (dig_r == DIG_W'(cbl_pkg::FF_DIGITS - 1));
  assign last_digit = top_digit;

  always_comb begin
    acc_nxt = acc_r;
    for (int i = 0; i < 3; i++)
      acc_nxt = acc_nxt + cbl_pkg::mul_digit(m_r[i], c_r[i][DW-1:0], top_digit);
  end

  assign x_shift = AW'($signed(x_r)) << cbl_pkg::IN_SHIFT[sec_r];
  assign ff_sel  = ff_r[sec_r];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbl_pkg::ST_IDLE:    if (in_fire) state_nxt = cbl_pkg::ST_READ;
      cbl_pkg::ST_READ:    state_nxt = cbl_pkg::ST_LOAD_FB;
      cbl_pkg::ST_LOAD_FB: state_nxt = cbl_pkg::ST_FB;
      cbl_pkg::ST_FB:      if (last_digit) state_nxt = cbl_pkg::ST_LOAD_FF;
      cbl_pkg::ST_LOAD_FF: state_nxt = cbl_pkg::ST_FF;
      cbl_pkg::ST_FF:      if (last_digit) state_nxt = cbl_pkg::ST_WRITE;
      cbl_pkg::ST_WRITE:
        state_nxt = (sec_r == SEC_W'(cbl_pkg::NUM_SECTIONS - 1)) ?
                    cbl_pkg::ST_FINISH : cbl_pkg::ST_READ;
      cbl_pkg::ST_FINISH:  if (out_free) state_nxt = cbl_pkg::ST_IDLE;
      default:             state_nxt = cbl_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = (state_r == cbl_pkg::ST_IDLE);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cbl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      sec_r       <= '0;
      dig_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == cbl_pkg::ST_FINISH && out_free) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        cbl_pkg::ST_IDLE:    sec_r <= '0;
        cbl_pkg::ST_LOAD_FB,
        cbl_pkg::ST_LOAD_FF: dig_r <= '0;
        cbl_pkg::ST_FB,
        cbl_pkg::ST_FF:      dig_r <= dig_r + 1'b1;
        cbl_pkg::ST_WRITE:   sec_r <= sec_r + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      cbl_pkg::ST_IDLE: begin
        if (in_fire) begin
          x_r    <= W'(in_data.sample_in);
          chin_r <= in_data.channel;
          ch_r   <= stereo_r & in_data.channel & (NUM_CHANNELS > 1);
        end
      end
      cbl_pkg::ST_LOAD_FB: begin
        w1_r   <= rd_w1;
        w2_r   <= rd_w2;
        acc_r  <= -x_shift;
        m_r[0] <= '0;
        c_r[0] <= '0;
        m_r[1] <= AW'($signed(rd_w2));
        c_r[1] <= cbl_pkg::FB_A2[sec_r];
        m_r[2] <= AW'($signed(rd_w1));
        c_r[2] <= cbl_pkg::FB_A1[sec_r];
      end
      cbl_pkg::ST_LOAD_FF: begin
        w0_r   <= acc_r[AW-1:cbl_pkg::FB_SHIFT];
        acc_r  <= '0;
        m_r[0] <= AW'($signed(acc_r[AW-1:cbl_pkg::FB_SHIFT]));
        c_r[0] <= ff_sel[CW-1:0];
        m_r[1] <= AW'($signed(w1_r));
        c_r[1] <= ff_sel[2*CW-1:CW];
        m_r[2] <= AW'($signed(w2_r));
        c_r[2] <= ff_sel[3*CW-1:2*CW];
      end
      cbl_pkg::ST_FB,
      cbl_pkg::ST_FF: begin
        acc_r <= acc_nxt;
        for (int i = 0; i < 3; i++) begin
          m_r[i] <= m_r[i] << DW;
          c_r[i] <= c_r[i] >> DW;
        end
      end
      cbl_pkg::ST_WRITE:   x_r <= acc_r[AW-1:cbl_pkg::FB_SHIFT];
      cbl_pkg::ST_FINISH: begin
        if (out_free) begin
          out_r.sample_out  <= $signed(x_r);
          out_r.channel_out <= chin_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: src/cbl_checker.sv
// cbl_checker: port-level assertions for cascaded_biquad_lowpass_unit, bound below
// depends on cbl_pkg and the top level's ports
module cbl_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input cbl_pkg::out_item_t             out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed or dropped while stalled");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // an accepted item keeps the block busy for the next cycles
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input accepted again too soon");

  // a new result appears only from an item in flight
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result item appeared while idle");

endmodule

bind cascaded_biquad_lowpass_unit cbl_checker u_cbl_checker (.*);
